// ===== sv/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants for the fixed-point alu pipeline.
// ----------------------------------------------------------------------------
package fpa_pkg;

   localparam int DATA_W = 32;
   localparam int DIV_STEPS = DATA_W;

   typedef enum logic [3:0] {
      OP_ADD     = 4'd0,
      OP_SUB     = 4'd1,
      OP_MUL     = 4'd2,
      OP_DIV     = 4'd3,
      OP_GT      = 4'd4,
      OP_LT      = 4'd5,
      OP_GE      = 4'd6,
      OP_LE      = 4'd7,
      OP_EQ      = 4'd8,
      OP_NE      = 4'd9,
      OP_MIN     = 4'd10,
      OP_MAX     = 4'd11,
      OP_INC     = 4'd12,
      OP_DEC     = 4'd13,
      OP_TOINT   = 4'd14,
      OP_FROMINT = 4'd15
   } op_type;

   // divider working set: partial remainder, dividend shifting out while
   // quotient bits shift in, and the divisor magnitude
   typedef struct packed {
      logic [DATA_W-1:0] rem;
      logic [DATA_W-1:0] quo;
      logic [DATA_W-1:0] dvs;
   } div_type;

   // everything else that rides along with the divider
   typedef struct packed {
      op_type            op;
      logic [DATA_W-1:0] res;
      logic              flag;
      logic              dz;
      logic              qneg;
   } side_type;

endpackage

// ===== sv/fixed_point_alu_unit.sv =====
// ----------------------------------------------------------------------------
// fixed_point_alu_unit
// Signed 32-bit fixed-point alu: add, sub, mul, div, compares, min/max,
// inc/dec and integer conversions, all through one uniform pipeline.
// ----------------------------------------------------------------------------
// throughput: one item per cycle while rsp_ready keeps the output draining; the divider yields one quotient bit per
// stage over 32 stages, with a prepare stage ahead and a result stage behind
// each stage holds while the one after it is full and stalled
// reset clears all valid bits; payload registers are not reset
module fixed_point_alu_unit #(
   parameter int FRAC_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_mode,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_result,
   output logic               rsp_flag,
   output logic               rsp_divide_by_zero
);

   localparam int W = fpa_pkg::DATA_W;
   localparam int N = fpa_pkg::DIV_STEPS;

   // stage enables, index N+1 is the output register
   logic [N+1:0]              en;
   logic [N:0]                vld_ff;
   logic                      rsp_valid_ff;

   // ---------------- prepare stage ----------------
   fpa_pkg::op_type           op;
   logic signed [W-1:0]       sum;
   logic signed [W-1:0]       dif;
   logic signed [W-1:0]       num;
   logic                      lt;
   logic                      eq;
   fpa_pkg::side_type         side0_in;
   fpa_pkg::div_type          div0_in;
   fpa_pkg::side_type         side0_ff;
   fpa_pkg::div_type          div0_ff;
   logic signed [W-1:0]       a0_ff;
   logic signed [W-1:0]       b0_ff;

   always_comb begin
      op  = fpa_pkg::op_type'(req_mode);
      sum = req_operand_a + req_operand_b;
      dif = req_operand_a - req_operand_b;
      lt  = req_operand_a < req_operand_b;
      eq  = req_operand_a == req_operand_b;
      num = req_operand_a <<< FRAC_BITS;

      side0_in.op   = op;
      side0_in.res  = '0;
      side0_in.flag = 1'b0;
      side0_in.dz   = 1'b0;
      side0_in.qneg = num[W-1] ^ req_operand_b[W-1];
      unique case (op)
         fpa_pkg::OP_ADD:     side0_in.res  = sum;
         fpa_pkg::OP_SUB:     side0_in.res  = dif;
         fpa_pkg::OP_MUL:     side0_in.res  = '0;
         fpa_pkg::OP_DIV:     side0_in.dz   = (req_operand_b == '0);
         fpa_pkg::OP_GT:      side0_in.flag = ~lt & ~eq;
         fpa_pkg::OP_LT:      side0_in.flag = lt;
         fpa_pkg::OP_GE:      side0_in.flag = ~lt;
         fpa_pkg::OP_LE:      side0_in.flag = lt | eq;
         fpa_pkg::OP_EQ:      side0_in.flag = eq;
         fpa_pkg::OP_NE:      side0_in.flag = ~eq;
         fpa_pkg::OP_MIN:     side0_in.res  = lt ? req_operand_a : req_operand_b;
         fpa_pkg::OP_MAX:     side0_in.res  = (~lt & ~eq) ? req_operand_a : req_operand_b;
         fpa_pkg::OP_INC:     side0_in.res  = req_operand_a + W'(1);
         fpa_pkg::OP_DEC:     side0_in.res  = req_operand_a - W'(1);
         fpa_pkg::OP_TOINT:   side0_in.res  = req_operand_a >>> FRAC_BITS;
         fpa_pkg::OP_FROMINT: side0_in.res  = num;
         default:             side0_in.res  = '0;
      endcase

      // magnitudes for the unsigned divider; -2^31 maps to 2^31 unchanged
      div0_in.rem = '0;
      div0_in.quo = num[W-1] ? -num : num;
      div0_in.dvs = req_operand_b[W-1] ? -req_operand_b : req_operand_b;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         side0_ff <= side0_in;
         div0_ff  <= div0_in;
         a0_ff    <= req_operand_a;
         b0_ff    <= req_operand_b;
      end
   end

   // ---------------- divider stages, multiply in the first ----------------
   logic signed [2*W-1:0]     prod;
   fpa_pkg::side_type         side1_in;
   fpa_pkg::side_type         side_ff [1:N];
   fpa_pkg::div_type          div_st  [1:N];

   assign prod = a0_ff * b0_ff;

   always_comb begin
      side1_in = side0_ff;
      if (side0_ff.op == fpa_pkg::OP_MUL) begin
         side1_in.res = prod[FRAC_BITS+W-1:FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         side_ff[1] <= side1_in;
      end
      for (int k = 2; k <= N; k++) begin
         if (en[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   for (genvar k = 1; k <= N; k++) begin : g_div
      if (k == 1) begin : g_first
         fpa_div_stage u_stage (
            .clock (clock),
            .en    (en[k]),
            .div_i (div0_ff),
            .div_o (div_st[k])
         );
      end else begin : g_next
         fpa_div_stage u_stage (
            .clock (clock),
            .en    (en[k]),
            .div_i (div_st[k-1]),
            .div_o (div_st[k])
         );
      end
   end

   // ---------------- result stage ----------------
   logic [W-1:0]              quo;
   logic [W-1:0]              res_in;
   logic [W-1:0]              res_ff;
   logic                      flag_ff;
   logic                      dz_ff;

   always_comb begin
      quo = div_st[N].quo;
      if (side_ff[N].op == fpa_pkg::OP_DIV) begin
         if (side_ff[N].dz) begin
            res_in = '0;
         end else begin
            res_in = side_ff[N].qneg ? -quo : quo;
         end
      end else begin
         res_in = side_ff[N].res;
      end
   end

   always_ff @(posedge clock) begin
      if (en[N+1]) begin
         res_ff  <= res_in;
         flag_ff <= side_ff[N].flag;
         dz_ff   <= side_ff[N].dz;
      end
   end

   // ---------------- valid chain ----------------
   // a stage loads when empty or when the next stage loads
   always_comb begin
      en[N+1] = ~rsp_valid_ff | rsp_ready;
      for (int k = N; k >= 0; k--) begin
         en[k] = ~vld_ff[k] | en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k <= N; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
         if (en[N+1]) begin
            rsp_valid_ff <= vld_ff[N];
         end
      end
   end

   assign req_ready          = en[0];
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result         = res_ff;
   assign rsp_flag           = flag_ff;
   assign rsp_divide_by_zero = dz_ff;

endmodule

// ===== sv/fpa_div_stage.sv =====
// ----------------------------------------------------------------------------
// fpa_div_stage
// One registered step of the restoring divider: produces one quotient bit.
// ----------------------------------------------------------------------------
module fpa_div_stage (
   input  logic              clock,
   input  logic              en,
   input  fpa_pkg::div_type  div_i,
   output fpa_pkg::div_type  div_o
);

   logic [fpa_pkg::DATA_W:0]   trial;
   logic [fpa_pkg::DATA_W:0]   diff;
   logic                       take;
   fpa_pkg::div_type           div_in;
   fpa_pkg::div_type           div_ff;

   always_comb begin
      trial = {div_i.rem, div_i.quo[fpa_pkg::DATA_W-1]};
      diff  = trial - {1'b0, div_i.dvs};
      take  = ~diff[fpa_pkg::DATA_W];
      div_in.rem = take ? diff[fpa_pkg::DATA_W-1:0] : trial[fpa_pkg::DATA_W-1:0];
      div_in.quo = {div_i.quo[fpa_pkg::DATA_W-2:0], take};
      div_in.dvs = div_i.dvs;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff <= div_in;
      end
   end

   assign div_o = div_ff;

endmodule
